// File: hw/rtl/hjbgs_pkg.sv
// Shared constants, types and fixed-point helpers for the HJB control search.
package hjbgs_pkg;

  localparam int unsigned CANDIDATES = 701;
  localparam int unsigned KW = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ACC_W = 24 + KW + 1;
  localparam logic [23:0] ALPHA_MAX = 24'hFFFFFF;

  localparam logic [2:0] REG_MU    = 3'd0;
  localparam logic [2:0] REG_R     = 3'd1;
  localparam logic [2:0] REG_HV    = 3'd2;
  localparam logic [2:0] REG_KX    = 3'd3;
  localparam logic [2:0] REG_KXX   = 3'd4;
  localparam logic [2:0] REG_A0    = 3'd5;
  localparam logic [2:0] REG_DA    = 3'd6;

  localparam logic [23:0] A0_RESET = 24'd3355443;
  localparam logic [23:0] DA_RESET = 24'd16777;

  typedef struct packed {
    logic [31:0] mu;
    logic [31:0] r;
    logic [30:0] hv;
    logic [31:0] kx;
    logic [31:0] kxx;
  } coef_t;

  // One candidate request travelling into the evaluator.
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [KW-1:0]      k;
    logic [23:0]        a;
    logic signed [31:0] x;
    logic signed [32:0] d1;
    logic signed [34:0] d2;
    logic signed [31:0] vc;
  } cand_t;

  // Round half away from zero after dropping sh bits, then saturate to
  // the range [-2^bits, 2^bits - 1].
  function automatic logic signed [51:0] rnd_sat(input logic signed [67:0] p,
                                                 input int unsigned sh,
                                                 input int unsigned bits);
    logic        neg;
    logic [67:0] mag;
    logic [67:0] lim;
    logic [67:0] res;
    neg = p[67];
    mag = neg ? (68'd0 - 68'(p)) : 68'(p);
    mag = (mag + (68'd1 << (sh - 1))) >> sh;
    lim = 68'd1 << bits;
    if (neg) begin
      res = (mag > lim) ? (68'd0 - lim) : (68'd0 - mag);
    end else begin
      res = (mag > lim - 68'd1) ? (lim - 68'd1) : mag;
    end
    return res[51:0];
  endfunction

endpackage

// File: hw/rtl/hjb_grid_point_control_search.sv
// Top level of the HJB grid point control search: config, sequencer, output.
//
// Each request on the in_ channel is one interior grid point: position and
// the left, center and right values of the later time row. The block sweeps
// all control candidates alpha_start + k*alpha_step (k = 0..700), one per
// clock while the output is not stalled, through a 12-stage evaluator, and
// keeps the first strict maximum. The out_ channel returns the saturated
// best value, its control and index. A new point is accepted in the cycle
// the previous one issues its last candidate, so sweeps follow each other
// without gaps. Configuration goes through the cfg_ APB port; the user must
// write it only while the block is idle, which the block does not enforce.
// Synchronous reset clears all control state and loads register defaults.
// When the receiver stalls with a result pending, the whole pipeline and
// the sequencer freeze; nothing is dropped or repeated.
module hjb_grid_point_control_search
  import hjbgs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_pos[31:0], value_left[63:32], value_center[95:64], value_right[127:96]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // best_value[31:0], best_alpha[55:32], best_index[65:56], zero pad[71:66]
  output logic [71:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [KW-1:0] K_LAST = KW'(CANDIDATES - 1);

  coef_t       coef_r;
  logic [23:0] a0_r, da_r;
  logic [2:0]  ridx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      a0_r   <= A0_RESET;
      da_r   <= DA_RESET;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_MU:  coef_r.mu  <= cfg_pwdata;
        REG_R:   coef_r.r   <= cfg_pwdata;
        REG_HV:  coef_r.hv  <= cfg_pwdata[30:0];
        REG_KX:  coef_r.kx  <= cfg_pwdata;
        REG_KXX: coef_r.kxx <= cfg_pwdata;
        REG_A0:  a0_r       <= cfg_pwdata[23:0];
        REG_DA:  da_r       <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MU:  cfg_prdata = coef_r.mu;
      REG_R:   cfg_prdata = coef_r.r;
      REG_HV:  cfg_prdata = {1'b0, coef_r.hv};
      REG_KX:  cfg_prdata = coef_r.kx;
      REG_KXX: cfg_prdata = coef_r.kxx;
      REG_A0:  cfg_prdata = {8'd0, a0_r};
      REG_DA:  cfg_prdata = {8'd0, da_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Sequencer
  logic               en;
  logic               busy_r, busy_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [31:0] x_r, vc_r;
  logic signed [32:0] d1_r;
  logic signed [34:0] d2_r;
  logic               issue_last;
  logic               in_acc;
  cand_t              cand_r, cand_nxt;
  logic signed [31:0] in_x, in_vl, in_vc, in_vr;

  logic               out_valid_r, out_valid_nxt;
  logic [71:0]        out_data_r;
  logic               res_valid;
  logic signed [31:0] res_value;
  logic [23:0]        res_alpha;
  logic [IDX_W-1:0]   res_index;

  assign en         = !out_valid_r || out_tready;
  assign issue_last = busy_r && (k_r == K_LAST);
  assign in_tready  = en && (!busy_r || issue_last);
  assign in_acc     = in_tvalid && in_tready;

  assign in_x  = in_tdata[31:0];
  assign in_vl = in_tdata[63:32];
  assign in_vc = in_tdata[95:64];
  assign in_vr = in_tdata[127:96];

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    cand_nxt = cand_r;
    if (en) begin
      cand_nxt.valid = busy_r;
      cand_nxt.first = (k_r == '0);
      cand_nxt.last  = issue_last;
      cand_nxt.k     = k_r;
      cand_nxt.a     = (acc_r > ACC_W'(ALPHA_MAX)) ? ALPHA_MAX : acc_r[23:0];
      cand_nxt.x     = x_r;
      cand_nxt.d1    = d1_r;
      cand_nxt.d2    = d2_r;
      cand_nxt.vc    = vc_r;
      if (busy_r) begin
        k_nxt   = k_r + KW'(1);
        acc_nxt = acc_r + ACC_W'(da_r);
        if (issue_last) busy_nxt = 1'b0;
      end
      if (in_acc) begin
        busy_nxt = 1'b1;
        k_nxt    = '0;
        acc_nxt  = ACC_W'(a0_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      k_r          <= '0;
      cand_r.valid <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      k_r          <= k_nxt;
      cand_r.valid <= cand_nxt.valid;
    end
    acc_r        <= acc_nxt;
    cand_r.first <= cand_nxt.first;
    cand_r.last  <= cand_nxt.last;
    cand_r.k     <= cand_nxt.k;
    cand_r.a     <= cand_nxt.a;
    cand_r.x     <= cand_nxt.x;
    cand_r.d1    <= cand_nxt.d1;
    cand_r.d2    <= cand_nxt.d2;
    cand_r.vc    <= cand_nxt.vc;
    if (in_acc) begin
      x_r  <= in_x;
      vc_r <= in_vc;
      d1_r <= 33'(in_vr) - 33'(in_vc);
      d2_r <= 35'(in_vr) - (35'(in_vc) <<< 1) + 35'(in_vl);
    end
  end

  hjbgs_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cand      (cand_r),
    .coef      (coef_r),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_alpha (res_alpha),
    .res_index (res_index)
  );

  // Output register; the pipeline only advances when it can take a result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) out_valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (en && res_valid) out_data_r <= {6'd0, res_index, res_alpha, res_value};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Intake must stop whenever a pending result is stalled.
  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline frozen");

  // A new point is only taken when the sequencer is idle or finishing.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!busy_r || k_r == K_LAST))
    else $error("input accepted mid-sweep");

  // The sweep counter never passes the last candidate.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r <= K_LAST))
    else $error("candidate counter out of range");

endmodule

// File: hw/rtl/hjbgs_eval.sv
// Pipelined candidate evaluator with running maximum over one grid point.
module hjbgs_eval
  import hjbgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  cand_t              cand,
  input  coef_t              coef,
  output logic               res_valid,
  output logic signed [31:0] res_value,
  output logic [23:0]        res_alpha,
  output logic [IDX_W-1:0]   res_index
);

  localparam int unsigned NST = 12;

  cand_t st_r [NST];

  logic signed [67:0] sq_r, rho1p_r;
  logic signed [31:0] a2_r, rho1_r;
  logic signed [67:0] rho2p_r, k1p_r;
  logic signed [31:0] rho2_r, k1_r;
  logic signed [67:0] k2p_r, g1p_r;
  logic signed [31:0] k2_r, g1a_r, g1b_r, g1c_r, g1d_r, g1e_r;
  logic signed [67:0] h2p_r;
  logic signed [31:0] h2_r;
  logic signed [67:0] g2p_r;
  logic signed [31:0] g2_r;
  logic signed [67:0] t1p_r, t2p_r;
  logic signed [52:0] sum_r;

  logic signed [52:0] best_r;
  logic [23:0]        best_a_r;
  logic [KW-1:0]      best_k_r;

  logic signed [24:0] a_s;
  logic signed [25:0] na_s;
  logic signed [67:0] pm, pr;
  logic signed [52:0] sum_nxt;
  logic               take;
  logic signed [52:0] best_nxt;
  logic [23:0]        best_a_nxt;
  logic [KW-1:0]      best_k_nxt;

  assign a_s  = {1'b0, cand.a};
  assign na_s = 26'sd16777216 - 26'(a_s);
  assign pm   = 68'(a_s * $signed(coef.mu));
  assign pr   = 68'(na_s * $signed(coef.r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) st_r[i].valid <= 1'b0;
    end else if (en) begin
      st_r[0].valid <= cand.valid;
      for (int i = 1; i < NST; i++) st_r[i].valid <= st_r[i-1].valid;
    end
    if (en) begin
      st_r[0].first <= cand.first;
      st_r[0].last  <= cand.last;
      st_r[0].k     <= cand.k;
      st_r[0].a     <= cand.a;
      st_r[0].x     <= cand.x;
      st_r[0].d1    <= cand.d1;
      st_r[0].d2    <= cand.d2;
      st_r[0].vc    <= cand.vc;
      for (int i = 1; i < NST; i++) begin
        st_r[i].first <= st_r[i-1].first;
        st_r[i].last  <= st_r[i-1].last;
        st_r[i].k     <= st_r[i-1].k;
        st_r[i].a     <= st_r[i-1].a;
        st_r[i].x     <= st_r[i-1].x;
        st_r[i].d1    <= st_r[i-1].d1;
        st_r[i].d2    <= st_r[i-1].d2;
        st_r[i].vc    <= st_r[i-1].vc;
      end
      // Stage 1: square of the control and the blended drift.
      sq_r    <= 68'(a_s * a_s);
      rho1p_r <= pm + pr;
      // Stage 2
      a2_r    <= 32'(rnd_sat(sq_r, 24, 31));
      rho1_r  <= 32'(rnd_sat(rho1p_r, 24, 31));
      // Stage 3
      rho2p_r <= 68'(a2_r * $signed({1'b0, coef.hv}));
      k1p_r   <= 68'(rho1_r * $signed(coef.kx));
      // Stage 4
      rho2_r  <= 32'(rnd_sat(rho2p_r, 24, 31));
      k1_r    <= 32'(rnd_sat(k1p_r, 24, 31));
      // Stage 5
      k2p_r   <= 68'(rho2_r * $signed(coef.kxx));
      g1p_r   <= 68'(k1_r * st_r[3].x);
      // Stage 6
      k2_r    <= 32'(rnd_sat(k2p_r, 24, 31));
      g1a_r   <= 32'(rnd_sat(g1p_r, 24, 31));
      // Stage 7
      h2p_r   <= 68'(k2_r * st_r[5].x);
      g1b_r   <= g1a_r;
      // Stage 8
      h2_r    <= 32'(rnd_sat(h2p_r, 24, 31));
      g1c_r   <= g1b_r;
      // Stage 9
      g2p_r   <= 68'(h2_r * st_r[7].x);
      g1d_r   <= g1c_r;
      // Stage 10
      g2_r    <= 32'(rnd_sat(g2p_r, 16, 31));
      g1e_r   <= g1d_r;
      // Stage 11
      t1p_r   <= 68'(g1e_r * st_r[9].d1);
      t2p_r   <= 68'(g2_r * st_r[9].d2);
      // Stage 12
      sum_r   <= sum_nxt;
    end
  end

  assign sum_nxt = 53'(st_r[10].vc) + 53'(rnd_sat(t1p_r, 16, 50))
                 + 53'(rnd_sat(t2p_r, 16, 50));

  // Strict compare keeps the first candidate on ties.
  assign take       = st_r[11].first || (sum_r > best_r);
  assign best_nxt   = take ? sum_r : best_r;
  assign best_a_nxt = take ? st_r[11].a : best_a_r;
  assign best_k_nxt = take ? st_r[11].k : best_k_r;

  always_ff @(posedge clk) begin
    if (en && st_r[11].valid) begin
      best_r   <= best_nxt;
      best_a_r <= best_a_nxt;
      best_k_r <= best_k_nxt;
    end
  end

  assign res_valid = st_r[11].valid && st_r[11].last;
  assign res_value = (best_nxt > 53'sd2147483647) ? 32'sh7FFFFFFF :
                     (best_nxt < -53'sd2147483648) ? 32'sh80000000 : 32'(best_nxt);
  assign res_alpha = best_a_nxt;
  assign res_index = IDX_W'(best_k_nxt);

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the HJB grid point control search block.
module tb_top
  import hjbgs_pkg::*;
();

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [31:0] mu;
    logic [31:0] r;
    logic [30:0] hv;
    logic [31:0] kx;
    logic [31:0] kxx;
    logic [23:0] a0;
    logic [23:0] da;
  } coef_regs_t;

  typedef struct {
    logic [31:0] best_value;
    logic [23:0] best_alpha;
    logic [9:0]  best_index;
  } best_control_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  coef_regs_t    coefs;
  best_control_t pending_best_q[$];
  int            errors;
  bit            hold_off_req;
  bit            calm;

  hjb_grid_point_control_search DUT (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Rounded and saturated product, shifted right by sh.
  function automatic longint mul_round_sat(longint p, longint q, int sh, int bits);
    logic signed [127:0] ps;
    logic signed [127:0] qs;
    logic signed [127:0] prod;
    logic [127:0]        mag;
    logic [127:0]        lim;
    ps = p;
    qs = q;
    prod = ps * qs;
    mag = prod[127] ? -prod : prod;
    mag = (mag + (128'd1 << (sh - 1))) >> sh;
    lim = 128'd1 << bits;
    if (prod[127]) begin
      return (mag > lim) ? -longint'(lim[63:0]) : -longint'(mag[63:0]);
    end
    return (mag > lim - 1) ? longint'(lim[63:0] - 1) : longint'(mag[63:0]);
  endfunction

  function automatic best_control_t search_controls(logic [31:0] xp, logic [31:0] vlp,
                                                    logic [31:0] vcp, logic [31:0] vrp);
    longint        x;
    longint        vl;
    longint        vc;
    longint        vr;
    longint        mu;
    longint        r;
    longint        hv;
    longint        kx;
    longint        kxx;
    longint        d1;
    longint        d2;
    longint        a;
    longint        a2;
    longint        rho1;
    longint        rho2;
    longint        k1;
    longint        k2;
    longint        g1;
    longint        h2;
    longint        g2;
    longint        sum;
    longint        best;
    best_control_t res;
    x = signed'(xp);
    vl = signed'(vlp);
    vc = signed'(vcp);
    vr = signed'(vrp);
    mu = signed'(coefs.mu);
    r = signed'(coefs.r);
    hv = coefs.hv;
    kx = signed'(coefs.kx);
    kxx = signed'(coefs.kxx);
    d1 = vr - vc;
    d2 = vr - 2 * vc + vl;
    best = 0;
    res.best_alpha = '0;
    res.best_index = '0;
    for (int k = 0; k < CANDIDATES; k++) begin
      a = longint'(coefs.a0) + longint'(k) * longint'(coefs.da);
      if (a > longint'(ALPHA_MAX)) a = ALPHA_MAX;
      a2 = mul_round_sat(a, a, 24, 31);
      rho1 = mul_round_sat(a * mu + ((64'sd1 << 24) - a) * r, 1, 24, 31);
      rho2 = mul_round_sat(a2, hv, 24, 31);
      k1 = mul_round_sat(rho1, kx, 24, 31);
      k2 = mul_round_sat(rho2, kxx, 24, 31);
      g1 = mul_round_sat(k1, x, 24, 31);
      h2 = mul_round_sat(k2, x, 24, 31);
      g2 = mul_round_sat(h2, x, 16, 31);
      sum = vc + mul_round_sat(g1, d1, 16, 50) + mul_round_sat(g2, d2, 16, 50);
      if (k == 0 || sum > best) begin
        best = sum;
        res.best_alpha = a[23:0];
        res.best_index = k[9:0];
      end
    end
    if (best > 64'sd2147483647) best = 64'sd2147483647;
    if (best < -64'sd2147483648) best = -64'sd2147483648;
    res.best_value = best[31:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_MU:  coefs.mu = data;
      REG_R:   coefs.r = data;
      REG_HV:  coefs.hv = data[30:0];
      REG_KX:  coefs.kx = data;
      REG_KXX: coefs.kxx = data;
      REG_A0:  coefs.a0 = data[23:0];
      REG_DA:  coefs.da = data[23:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic load_coefs(logic [31:0] mu, logic [31:0] r, logic [31:0] hv,
                            logic [31:0] kx, logic [31:0] kxx, logic [31:0] a0,
                            logic [31:0] da);
    cfg_write(REG_MU, mu);
    cfg_write(REG_R, r);
    cfg_write(REG_HV, hv);
    cfg_write(REG_KX, kx);
    cfg_write(REG_KXX, kxx);
    cfg_write(REG_A0, a0);
    cfg_write(REG_DA, da);
  endtask

  // The expectation is formed at the accepting edge, with the registers
  // that the block holds at that moment.
  task automatic send_point(logic [31:0] x, logic [31:0] vl, logic [31:0] vc,
                            logic [31:0] vr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vr, vc, vl, x};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_best_q.push_back(search_controls(x, vl, vc, vr));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_best_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h7FFFFF) - 32'h400000;
      default: return 32'h10000 * $urandom_range(0, 20) + $urandom_range(0, 32'hFFFF);
    endcase
  endfunction

  task automatic send_random_point();
    logic [31:0] x;
    logic [31:0] v;
    x = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'hA0000);
    v = rand_value();
    if ($urandom_range(0, 3) == 0) begin
      send_point(x, rand_value(), rand_value(), rand_value());
    end else begin
      // A smooth neighborhood: the three values lie close together.
      send_point(x, v + $urandom_range(0, 32'h3FFF) - 32'h2000, v,
                 v + $urandom_range(0, 32'h3FFF) - 32'h2000);
    end
  endtask

  task automatic load_random_coefs();
    if ($urandom_range(0, 4) == 0) begin
      load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
    end else begin
      load_coefs($urandom_range(0, 32'h400000), $urandom_range(0, 32'h100000),
                 $urandom_range(0, 32'h800000), $urandom_range(0, 32'h2000000),
                 $urandom_range(0, 32'h8000000), $urandom_range(0, 32'h800000),
                 $urandom_range(0, 32'h8000));
    end
  endtask

  // With all coefficients zero every candidate ties, so the first one wins.
  task automatic test_reset_defaults();
    send_point(32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_point(32'h7FFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    load_coefs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h0, 32'h5000);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_point(32'h0, 32'h7FFFFFFF, 32'h0, 32'h80000000);
    send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    wait_idle();
    load_coefs(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h80000000,
               32'h00FFFFFF, 32'h0);
    send_point(32'h7FFFFFFF, 32'h00010000, 32'h80000000, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_point(32'h00030000, 32'h00012000, 32'h00010000, 32'h0000F000);
    wait_idle();
  endtask

  // Candidates run past one and clamp; out-of-range writes are dropped and
  // wide values are masked to the register width.
  task automatic test_alpha_clamp_and_masking();
    load_coefs(32'h01800000, 32'h00080000, 32'hFFFFFFFF, 32'h00400000, 32'h00200000,
               32'hFFFF0000, 32'hFF00F000);
    cfg_write(REG_UNUSED, 32'h12345678);
    send_point(32'h00020000, 32'h00011000, 32'h00010000, 32'h00013000);
    send_point(32'h00050000, 32'hFFFF0000, 32'h00000000, 32'h00010000);
    wait_idle();
    load_coefs(32'h01000000, 32'h00080000, 32'h00100000, 32'h00800000, 32'h01000000,
               32'h00F00000, 32'h00FFFFFF);
    send_point(32'h00040000, 32'h00020000, 32'h00010000, 32'h00030000);
    send_point(32'h00040000, 32'h00010000, 32'h00020000, 32'h00010000);
    wait_idle();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_random_coefs();
      calm = (p % 4 == 3);
      for (int i = 0; i < per_phase; i++) send_random_point();
      wait_idle();
    end
    calm = 1'b0;
  endtask

  // The receiver stops for a long time while points keep coming.
  task automatic test_backpressure();
    load_random_coefs();
    calm = 1'b1;
    hold_off_req = 1'b1;
    repeat (2) @(posedge clk);
    hold_off_req = 1'b0;
    for (int i = 0; i < 10; i++) send_random_point();
    calm = 1'b0;
    wait_idle();
  endtask

  always @(posedge clk) begin : receiver
    int stall_cnt;
    if (hold_off_req && stall_cnt < 2000) begin
      stall_cnt = 4000;
    end
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 3) stall_cnt = pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    best_control_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_best_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = pending_best_q.pop_front();
        if (out_tdata[31:0] !== want.best_value || out_tdata[55:32] !== want.best_alpha ||
            out_tdata[65:56] !== want.best_index) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: value %h alpha %h index %0d, expected %h %h %0d",
                     out_tdata[31:0], out_tdata[55:32], out_tdata[65:56],
                     want.best_value, want.best_alpha, want.best_index);
          end
        end
      end
    end
  end

  initial begin
    #100000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    hold_off_req = 1'b0;
    calm = 1'b0;
    coefs = '{mu: '0, r: '0, hv: '0, kx: '0, kxx: '0, a0: A0_RESET, da: DA_RESET};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_alpha_clamp_and_masking();
    test_backpressure();
    test_random_phases(8, 102);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
